// ----- src/bdq_pkg.sv -----
// Package for the bounded array deque: payload structs, command and status codes,
// and the control and status structs between controller and datapath.
// No dependencies.
package bdq_pkg;

    localparam int DEF_DEPTH = 64;
    localparam int DATA_W    = 32;
    localparam int OPC_W     = 3;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 6;

    localparam logic [OPC_W-1:0] OP_PUSH_LEFT  = 3'd0;
    localparam logic [OPC_W-1:0] OP_POP_LEFT   = 3'd1;
    localparam logic [OPC_W-1:0] OP_PUSH_RIGHT = 3'd2;
    localparam logic [OPC_W-1:0] OP_POP_RIGHT  = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] push_value;
    } s_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] pop_value;
        logic [OCC_W-1:0]  occupancy;
    } m_item_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH_L,
        ACT_POP_L,
        ACT_PUSH_R,
        ACT_POP_R,
        ACT_CLEAR
    } act_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic              exec;
        act_t              act;
        logic [STAT_W-1:0] status;
    } dp_cmd_t;

    // Edge conditions reported by the datapath.
    typedef struct packed {
        logic empty;
        logic left_full;
        logic right_full;
    } dp_stat_t;

endpackage

// ----- src/bdq_ctrl.sv -----
// Controller for the bounded array deque: two-state handshake sequencer and
// command decoder. Depends on bdq_pkg.
module bdq_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [bdq_pkg::OPC_W-1:0] opcode,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  bdq_pkg::dp_stat_t       stat,
    output bdq_pkg::dp_cmd_t        cmd
);
    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_RESP);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode the command against the current edge conditions.
    always_comb begin
        cmd.exec   = s_valid && s_ready;
        cmd.act    = ACT_NONE;
        cmd.status = ST_OK;
        unique case (opcode)
            OP_PUSH_LEFT: begin
                if (stat.left_full) begin
                    cmd.status = ST_FULL;
                end else begin
                    cmd.act = ACT_PUSH_L;
                end
            end
            OP_POP_LEFT: begin
                if (stat.empty) begin
                    cmd.status = ST_EMPTY;
                end else begin
                    cmd.act = ACT_POP_L;
                end
            end
            OP_PUSH_RIGHT: begin
                if (stat.right_full) begin
                    cmd.status = ST_FULL;
                end else begin
                    cmd.act = ACT_PUSH_R;
                end
            end
            OP_POP_RIGHT: begin
                if (stat.empty) begin
                    cmd.status = ST_EMPTY;
                end else begin
                    cmd.act = ACT_POP_R;
                end
            end
            OP_CLEAR: cmd.act = ACT_CLEAR;
            default: cmd.act = ACT_NONE;
        endcase
    end

    a_exec_then_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("accepted command did not produce a result beat");

    a_resp_taken_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("controller did not return to idle after result beat");

    a_refused_no_act: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.status != ST_OK) |-> (cmd.act == ACT_NONE))
        else $error("refused command still issued a datapath action");

endmodule

// ----- src/bdq_datapath.sv -----
// Datapath for the bounded array deque: edge pointers, element count,
// element store with registered read, and result registers. Depends on bdq_pkg.
module bdq_datapath #(
    parameter int DEPTH = bdq_pkg::DEF_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bdq_pkg::dp_cmd_t           cmd,
    input  logic [bdq_pkg::DATA_W-1:0] push_value,
    output bdq_pkg::dp_stat_t          stat,
    output bdq_pkg::m_item_t           m_item
);
    import bdq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LEFT_RST  = PW'(DEPTH / 2 - 1);
    localparam logic [PW-1:0] RIGHT_RST = PW'(DEPTH / 2);
    localparam logic [PW-1:0] TOP_SLOT  = PW'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [PW-1:0]     left_reg, left_next;
    logic [PW-1:0]     right_reg, right_next;
    logic [PW-1:0]     count_reg, count_next;
    logic [STAT_W-1:0] status_reg;
    logic              popped_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic              wr_en, rd_en;
    logic [PW-1:0]     wr_addr, rd_addr;

    assign stat.empty      = ({1'b0, left_reg} + 1'b1) == {1'b0, right_reg};
    assign stat.left_full  = (left_reg == '0);
    assign stat.right_full = (right_reg == TOP_SLOT);

    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = left_reg;
        rd_addr    = left_reg + 1'b1;
        case (cmd.act)
            ACT_PUSH_L: begin
                wr_en      = 1'b1;
                left_next  = left_reg - 1'b1;
                count_next = count_reg + 1'b1;
            end
            ACT_POP_L: begin
                rd_en      = 1'b1;
                left_next  = left_reg + 1'b1;
                count_next = count_reg - 1'b1;
            end
            ACT_PUSH_R: begin
                wr_en      = 1'b1;
                wr_addr    = right_reg;
                right_next = right_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
            ACT_POP_R: begin
                rd_en      = 1'b1;
                rd_addr    = right_reg - 1'b1;
                right_next = right_reg - 1'b1;
                count_next = count_reg - 1'b1;
            end
            ACT_CLEAR: begin
                left_next  = LEFT_RST;
                right_next = RIGHT_RST;
                count_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= LEFT_RST;
            right_reg <= RIGHT_RST;
            count_reg <= '0;
        end else if (cmd.exec) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= cmd.status;
            popped_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= push_value;
        end
        if (cmd.exec && rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_item.status    = status_reg;
    assign m_item.pop_value = popped_reg ? rd_data_reg : '0;
    assign m_item.occupancy = OCC_W'(count_reg);

    a_count_matches_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == PW'(right_reg - left_reg - 1'b1))
        else $error("element count disagrees with edge pointers");

    a_edges_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg < right_reg)
        else $error("left edge crossed right edge");

    a_refused_holds_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && cmd.status != ST_OK) |=>
            ($stable(left_reg) && $stable(right_reg) && $stable(count_reg)))
        else $error("refused command moved an edge");

endmodule

// ----- src/bounded_array_deque.sv -----
// Top level of the bounded array deque: handshake controller plus datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
// A double-ended queue of 32-bit words in a flat store of DEPTH slots that
// never wraps. Each input beat carries one command (push left, pop left, push
// right, pop right, clear) and produces exactly one result beat with a status
// (ok, full, empty), the popped word (zero unless a pop succeeded) and the
// occupancy after the command, reported modulo 64. Elements live strictly
// between the left and right edge pointers, which start at DEPTH/2-1 and
// DEPTH/2; slots 0 and DEPTH-1 are never used, so at most DEPTH-2 words fit
// and one end can report full while the other still has room. Opcodes 5 to 7
// change nothing and report ok. A command is accepted in the idle cycle; the
// edge update, store write or registered store read happens at the edge that
// ends that cycle, and the result beat is then held in the output register
// until it is taken, after which the next command is accepted. The store has
// one write port and one registered read port and needs no clearing pass
// after reset.
module bounded_array_deque #(
    parameter int DEPTH = bdq_pkg::DEF_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bdq_pkg::s_item_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output bdq_pkg::m_item_t  m_item
);
    import bdq_pkg::*;

    // Command from the controller and edge conditions back from the datapath.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    bdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_item.opcode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .push_value (s_item.push_value),
        .stat       (stat),
        .m_item     (m_item)
    );

    // The block handles one command at a time, so the two sides never overlap.
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides active together");

    // A failed pop must report a zero word.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == ST_EMPTY) |-> (m_item.pop_value == '0))
        else $error("empty pop returned a nonzero word");

    // A left push accepted while the left edge sits at slot 0 is refused as full.
    a_full_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.opcode == OP_PUSH_LEFT && stat.left_full)
            |=> (m_item.status == ST_FULL))
        else $error("left push at the bound was not refused");

endmodule
